[rtl/kwm_pkg.sv]
// Shared types and codes for the k-way sorted list merge engine.
`timescale 1ns / 1ps
package kwm_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;

  localparam logic [2:0] ST_APPENDED = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_POPPED   = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_OUT
  } kwm_state_t;

endpackage

[rtl/k_way_sorted_list_merge.sv]
// Top level of the k-way sorted list merge engine.
`timescale 1ns / 1ps
// Usage:
//   Input stream in_*: in_tdata holds list_index in bits 2:0 and value in
//   bits 34:3, zero padded to 40 bits; in_tuser = command (0 append, 1 pop,
//   other clear).
//   Output stream out_*: out_tdata holds popped_value in bits 31:0 and
//   source_list in bits 34:32, zero padded to 40 bits; out_tuser = status.
//   Each command gives exactly one result. A pop reads the head word of every
//   list from the list memory, one list per cycle, through its single read
//   port while a running minimum is kept.
//   One command is worked at a time; the next is taken once the result has
//   moved into the output register. While the receiver stalls the result
//   holds in the output register; one more command is taken and worked, then
//   waits for the output register with in_tready low.
//   Reset clears all fill and read counters, so every list is empty; list
//   memory contents are not cleared, and a word is only used once written.
module k_way_sorted_list_merge
  import kwm_pkg::*;
#(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // list_index[2:0], value[34:3], zero pad
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // popped_value[31:0], source_list[34:32], zero pad
  output logic [2:0]  out_tuser   // status
);

  localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int DW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = LW + DW;
  localparam int MEM_DEPTH = NUM_LISTS << DW;

  logic [31:0] mem [MEM_DEPTH];
  logic [CW-1:0] fill_r [NUM_LISTS];
  logic [CW-1:0] rpos_r [NUM_LISTS];

  kwm_state_t state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [2:0]  idx_r;
  logic [31:0] val_r;
  logic [LW:0] scan_r;          // list being addressed
  logic        rd_vld_r;        // read data valid this cycle
  logic [LW-1:0] rd_list_r;
  logic        found_r;
  logic [LW-1:0] best_r;
  logic [31:0] best_val_r;
  logic [31:0] rd_data_r;
  logic        ovld_r;
  logic [2:0]  ost_r;
  logic [31:0] oval_r;
  logic [2:0]  osrc_r;

  logic accept;
  logic out_free;
  logic [LW-1:0] scan_l;
  logic [LW-1:0] idx_l;
  logic live_scan;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic idx_ok;
  logic app_ok;

  assign out_free  = !ovld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign scan_l    = scan_r[LW-1:0];
  assign idx_l     = LW'(idx_r);
  assign live_scan = (scan_r < (LW+1)'(NUM_LISTS)) && (rpos_r[scan_l] < fill_r[scan_l]);
  assign rd_addr   = {scan_l, rpos_r[scan_l][DW-1:0]};
  assign idx_ok    = (32'(idx_r) < NUM_LISTS);
  assign app_ok    = idx_ok && (fill_r[idx_l] < CW'(LIST_DEPTH));
  assign wr_addr   = {idx_l, fill_r[idx_l][DW-1:0]};

  always_ff @(posedge clk) begin
    if (state_r == S_PICK && cmd_r == CMD_APPEND && app_ok) begin
      mem[wr_addr] <= val_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = (in_tuser == CMD_POP) ? S_SCAN : S_PICK;
      S_SCAN: if (scan_r == (LW+1)'(NUM_LISTS) && !rd_vld_r) state_nxt = S_PICK;
      S_PICK: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovld_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      scan_r   <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_r[i] <= '0;
        rpos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) ovld_r <= 1'b1;
      else if (out_tready) ovld_r <= 1'b0;
      if (accept) begin
        cmd_r   <= in_tuser;
        idx_r   <= in_tdata[2:0];
        val_r   <= in_tdata[34:3];
        scan_r  <= '0;
        found_r <= 1'b0;
        rd_vld_r <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        // address next list, compare the word that came back
        rd_vld_r  <= live_scan;
        rd_list_r <= scan_l;
        if (scan_r != (LW+1)'(NUM_LISTS)) scan_r <= scan_r + 1'b1;
        if (rd_vld_r && (!found_r ||
            $signed(rd_data_r) < $signed(best_val_r))) begin
          found_r    <= 1'b1;
          best_r     <= rd_list_r;
          best_val_r <= rd_data_r;
        end
      end
      if (state_r == S_PICK) begin
        priority if (cmd_r == CMD_APPEND) begin
          ost_r <= app_ok ? ST_APPENDED : ST_DROPPED;
          if (app_ok) fill_r[idx_l] <= fill_r[idx_l] + 1'b1;
          oval_r <= '0; osrc_r <= '0;
        end else if (cmd_r == CMD_POP) begin
          ost_r  <= found_r ? ST_POPPED : ST_EMPTY;
          oval_r <= found_r ? best_val_r : '0;
          osrc_r <= found_r ? 3'(best_r) : '0;
          if (found_r) rpos_r[best_r] <= rpos_r[best_r] + 1'b1;
        end else begin
          ost_r <= ST_CLEARED;
          oval_r <= '0; osrc_r <= '0;
          for (int i = 0; i < NUM_LISTS; i++) begin
            fill_r[i] <= '0;
            rpos_r[i] <= '0;
          end
        end
      end
    end
  end

  // result is loaded into the output register on leaving S_OUT
  logic [2:0]  hst_r;
  logic [31:0] hval_r;
  logic [2:0]  hsrc_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      hst_r <= ost_r; hval_r <= oval_r; hsrc_r <= osrc_r;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = hst_r;
  assign out_tdata  = {5'd0, hsrc_r, hval_r};

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_pop_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_POPPED) |-> out_tdata[34:0] == '0)
    else $error("nonzero payload on non-pop result");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> out_tvalid) else $error("result lost");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= (LW+1)'(NUM_LISTS)) else $error("scan out of range");
`endif

endmodule

[tb/tb_k_way_sorted_list_merge.sv]
// Testbench for the k-way sorted list merge engine: append, pop and clear checked against a merge predictor.
`timescale 1ns / 1ps
module tb_k_way_sorted_list_merge;
  import kwm_pkg::*;

  localparam int NLISTS = 8;
  localparam int DEPTH = 256;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] popped;
    logic [2:0]  src;
  } merge_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  k_way_sorted_list_merge dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  logic [31:0]   list_words [NLISTS][DEPTH];
  int            fill_count [NLISTS];
  int            read_count [NLISTS];
  merge_result_t pending_results [$];
  int            mismatches;
  int            results_seen;
  int            cycles;
  int            stall_mode;

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic merge_result_t merge_predict(logic [1:0] cmd, logic [2:0] idx,
                                                  logic [31:0] val);
    merge_result_t r;
    int best;
    logic signed [31:0] best_word;
    logic signed [31:0] w;
    r = '0;
    best = -1;
    best_word = 0;
    if (cmd == CMD_APPEND) begin
      if (fill_count[idx] < DEPTH) begin
        list_words[idx][fill_count[idx]] = val;
        fill_count[idx]++;
        r.status = ST_APPENDED;
      end else begin
        r.status = ST_DROPPED;
      end
    end else if (cmd == CMD_POP) begin
      for (int i = 0; i < NLISTS; i++) begin
        if (read_count[i] < fill_count[i]) begin
          w = list_words[i][read_count[i]];
          // strict less keeps ties on the lower index
          if (best < 0 || w < best_word) begin
            best = i;
            best_word = w;
          end
        end
      end
      if (best >= 0) begin
        read_count[best]++;
        r.status = ST_POPPED;
        r.popped = best_word;
        r.src = best[2:0];
      end else begin
        r.status = ST_EMPTY;
      end
    end else begin
      for (int i = 0; i < NLISTS; i++) begin
        fill_count[i] = 0;
        read_count[i] = 0;
      end
      r.status = ST_CLEARED;
    end
    return r;
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [2:0] idx, logic [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {5'd0, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.insert(pending_results.size(), merge_predict(cmd, idx, val));
  endtask

  task automatic idle_sender(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one item, sometimes followed by a random idle gap; repeated calls form random bursts
  task automatic send_burst_gap(logic [1:0] cmd, logic [2:0] idx, logic [31:0] val);
    send_request(cmd, idx, val);
    if ($urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 12));
  endtask

  // receiver stall pattern, changed per phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk) begin
    merge_result_t got;
    merge_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("k_way_sorted_list_merge test failed");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[31:0], out_tdata[34:32]};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.popped != want.popped || got.src != want.src)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d value %h/%h list %0d/%0d (exp/act)",
                     want.status, got.status, want.popped, got.popped, want.src, got.src);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_POP, 3'd0, 32'd0);
    send_request(CMD_APPEND, 3'd0, 32'h7FFF_FFFF);
    send_request(CMD_APPEND, 3'd7, 32'h8000_0000);
    send_request(CMD_APPEND, 3'd3, 32'h8000_0000);
    send_request(CMD_APPEND, 3'd5, 32'hFFFF_FFFF);
    send_request(CMD_APPEND, 3'd2, 32'h0000_0000);
    send_request(CMD_APPEND, 3'd1, 32'h7FFF_FFFF);
    repeat (7) send_request(CMD_POP, 3'd7, 32'hFFFF_FFFF);
    send_request(CMD_APPEND, 3'd0, 32'h5555_AAAA);
    send_request(CMD_POP, 3'd0, 32'd0);
    send_request(CMD_APPEND, 3'd4, 32'd1);
    send_request(CMD_SPARE, 3'd4, 32'd1);
    send_request(CMD_POP, 3'd0, 32'd0);
    send_request(CMD_APPEND, 3'd6, 32'hAAAA_5555);
    send_request(CMD_CLEAR, 3'd0, 32'd0);
    send_request(CMD_POP, 3'd0, 32'd0);
    drain_results();
  endtask

  // fill one list to the top, overflow it, then merge everything out
  task automatic test_full_list();
    for (int i = 0; i < DEPTH + 3; i++)
      send_burst_gap(CMD_APPEND, 3'd6, $urandom());
    send_request(CMD_APPEND, 3'd1, 32'd9);
    for (int i = 0; i < DEPTH + 2; i++) send_burst_gap(CMD_POP, 3'd0, 32'd0);
    send_request(CMD_APPEND, 3'd6, 32'd3);
    send_request(CMD_CLEAR, 3'd0, 32'd0);
    drain_results();
  endtask

  // random values on random lists, merged out, with some noise
  task automatic test_random_merge(int rounds);
    logic [31:0] base;
    int n;
    for (int r = 0; r < rounds; r++) begin
      n = $urandom_range(4, 24);
      for (int k = 0; k < n; k++) begin
        base = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15) - 8;
        send_burst_gap(CMD_APPEND, 3'($urandom_range(0, 7)), base);
        if ($urandom_range(0, 7) == 0) send_burst_gap(CMD_POP, 3'd0, $urandom());
      end
      for (int k = 0; k < n + $urandom_range(0, 2); k++)
        send_burst_gap(CMD_POP, 3'($urandom()), $urandom());
      if ($urandom_range(0, 4) == 0)
        send_burst_gap($urandom_range(0, 1) ? CMD_CLEAR : CMD_SPARE, 3'($urandom()),
                       $urandom());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_APPEND;
    out_tready = 1'b0;
    stall_mode = 0;
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    for (int i = 0; i < NLISTS; i++) begin
      fill_count[i] = 0;
      read_count[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_mode = 1;
    test_full_list();
    stall_mode = 2;
    test_random_merge(14);
    stall_mode = 0;
    test_random_merge(11);
    stall_mode = 1;
    test_random_merge(11);
    drain_results();
    repeat (40) @(posedge clk);
    $display("covered %0d results: extremes, ties, full and refilled lists,", results_seen);
    $display("clears and the spare command under bursty sender and stalled receiver");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("k_way_sorted_list_merge test passed");
    end else begin
      $display("k_way_sorted_list_merge test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/kwm_pkg.sv
rtl/k_way_sorted_list_merge.sv
tb/tb_k_way_sorted_list_merge.sv
